// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the resampler RTL.
// Expects signals named clock and reset in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SRAR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition must never be seen outside reset.
`define SRAR_ASSERT_NEVER(label, cond, msg) \
   `SRAR_ASSERT(label, !(cond), msg)

`endif

// ----- hdl/srar_pkg.sv -----
// Types, widths and constants of the stereo ring resampler.
// No dependencies; every other resampler file but assert_macros.svh refers to it by scoped names.
package srar_pkg;

   localparam int RING_FRAMES   = 1024;
   localparam int SAMPLE_BITS   = 24;
   localparam int FRACTION_BITS = 24;

   localparam int RING_BITS  = $clog2(RING_FRAMES);
   localparam int COUNT_BITS = 32;
   localparam int POS_BITS   = COUNT_BITS + FRACTION_BITS;

   // Q1.16 fill level, 65536 means full
   localparam int FILL_BITS  = 17;
   localparam int FILL_SHIFT = FRACTION_BITS + RING_BITS - 16;
   localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(65536);

   localparam logic [POS_BITS-1:0] ONE_FIX  = POS_BITS'(1) << FRACTION_BITS;
   localparam logic [POS_BITS-1:0] FULL_FIX = POS_BITS'(RING_FRAMES) << FRACTION_BITS;

   // configuration port
   localparam int REG_BITS       = 32;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BASE_RATIO  = 2'd0,
      CSR_FILL_GAIN   = 2'd1,
      CSR_TARGET_FILL = 2'd2
   } csr_index_type;

   localparam logic [REG_BITS-1:0]  BASE_RATIO_RESET  = 32'd16777216;
   localparam logic [REG_BITS-1:0]  FILL_GAIN_RESET   = 32'd16777216;
   localparam logic [FILL_BITS-1:0] TARGET_FILL_RESET = 17'd32768;

   // rate adjustment: Q8.24 gain times signed Q1.16 error gives Q.40
   localparam int ERR_BITS       = FILL_BITS + 1;
   localparam int GAIN_PROD_BITS = REG_BITS + 1 + ERR_BITS;
   localparam int SUM_BITS       = GAIN_PROD_BITS + 1;
   localparam int ADJ_BITS       = 25;
   localparam int ADJ_SHIFT      = 16;
   localparam logic [ADJ_BITS-1:0] ADJ_LO = 25'd16693330;
   localparam logic [ADJ_BITS-1:0] ADJ_HI = 25'd16861102;
   localparam logic signed [SUM_BITS-1:0] UNITY_SUM  = SUM_BITS'(64'd1 << 40);
   localparam logic signed [SUM_BITS-1:0] ADJ_LO_SUM = SUM_BITS'(ADJ_LO) << ADJ_SHIFT;
   localparam logic signed [SUM_BITS-1:0] ADJ_HI_SUM = SUM_BITS'(ADJ_HI) << ADJ_SHIFT;

   // read step: Q8.24 ratio times Q.24 adjust, brought to the position's fraction
   localparam int STEP_PROD_BITS = REG_BITS + ADJ_BITS;
   localparam int STEP_SHIFT     = 48 - FRACTION_BITS;

   localparam int DIFF_BITS   = SAMPLE_BITS + 1;
   localparam int INTERP_BITS = DIFF_BITS + FRACTION_BITS + 1;

   // command queue between front and back
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef struct packed {
      op_type                         kind;
      logic                           eob;
      logic signed [SAMPLE_BITS-1:0]  left;
      logic signed [SAMPLE_BITS-1:0]  right;
   } cmd_type;

endpackage

// ----- hdl/srar_chan_if.sv -----
// Valid/ready channel interfaces for resampler requests and responses.
// Depends on srar_pkg for sample and fill widths.
interface srar_req_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    operation;
   logic signed [srar_pkg::SAMPLE_BITS-1:0] left_in;
   logic signed [srar_pkg::SAMPLE_BITS-1:0] right_in;
   logic                                    end_of_block;

   modport source (output valid, operation, left_in, right_in, end_of_block, input ready);
   modport sink   (input valid, operation, left_in, right_in, end_of_block, output ready);
endinterface

interface srar_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [srar_pkg::SAMPLE_BITS-1:0] left_out;
   logic signed [srar_pkg::SAMPLE_BITS-1:0] right_out;
   logic                                    underrun_now;
   logic                                    overrun_now;
   logic [srar_pkg::FILL_BITS-1:0]          fill_level;
   logic [srar_pkg::COUNT_BITS-1:0]         underrun_total;
   logic [srar_pkg::COUNT_BITS-1:0]         overrun_total;

   modport source (output valid, left_out, right_out, underrun_now, overrun_now, fill_level,
                   underrun_total, overrun_total, input ready);
   modport sink   (input valid, left_out, right_out, underrun_now, overrun_now, fill_level,
                   underrun_total, overrun_total, output ready);
endinterface

// ----- hdl/srar_front.sv -----
// Request front end: accepts beats, decodes push or pop, queues commands.
// Depends on srar_pkg and srar_req_if.
module srar_front (
   input  logic               clock,
   input  logic               reset,
   srar_req_if.sink           req_ch,
   output logic               q_valid,
   input  logic               q_ready,
   output srar_pkg::cmd_type  q_cmd
);

   srar_pkg::cmd_type                       queue_ff [srar_pkg::QUEUE_DEPTH];
   logic [srar_pkg::QUEUE_PTR_BITS-1:0]     wr_ptr_ff;
   logic [srar_pkg::QUEUE_PTR_BITS-1:0]     rd_ptr_ff;
   logic [srar_pkg::QUEUE_COUNT_BITS-1:0]   count_ff;
   logic [srar_pkg::QUEUE_COUNT_BITS-1:0]   count_in;
   srar_pkg::cmd_type                       cmd_in;
   logic                                    enq;
   logic                                    deq;

   assign req_ch.ready = (count_ff != srar_pkg::QUEUE_COUNT_BITS'(srar_pkg::QUEUE_DEPTH));
   assign q_valid      = (count_ff != '0);
   assign q_cmd        = queue_ff[rd_ptr_ff];

   assign enq = req_ch.valid && req_ch.ready;
   assign deq = q_valid && q_ready;

   always_comb begin
      cmd_in.kind  = req_ch.operation ? srar_pkg::OP_POP : srar_pkg::OP_PUSH;
      cmd_in.eob   = req_ch.end_of_block;
      cmd_in.left  = req_ch.left_in;
      cmd_in.right = req_ch.right_in;
   end

   assign count_in = count_ff + srar_pkg::QUEUE_COUNT_BITS'(enq)
                              - srar_pkg::QUEUE_COUNT_BITS'(deq);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (enq) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (deq) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
      if (enq) begin
         queue_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

// ----- hdl/srar_back.sv -----
// Execution back end: frame store, read position control, interpolation, result register.
// Depends on srar_pkg, srar_rsp_if and assert_macros.svh.
`include "assert_macros.svh"

module srar_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [srar_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [srar_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  logic                                  q_valid,
   output logic                                  q_ready,
   input  srar_pkg::cmd_type                     q_cmd,
   srar_rsp_if.source                            rsp_ch
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADJ,
      ST_STEP,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [srar_pkg::REG_BITS-1:0]   base_ratio_ff;
   logic [srar_pkg::REG_BITS-1:0]   fill_gain_ff;
   logic [srar_pkg::FILL_BITS-1:0]  target_fill_ff;

   // ring state
   logic [srar_pkg::COUNT_BITS-1:0]      write_count_ff;
   logic [srar_pkg::POS_BITS-1:0]        read_pos_ff;
   logic signed [srar_pkg::POS_BITS-1:0] avail_ff;
   logic [srar_pkg::COUNT_BITS-1:0]      underrun_count_ff;
   logic [srar_pkg::COUNT_BITS-1:0]      overrun_count_ff;
   logic                                 under_blk_ff;
   logic                                 over_blk_ff;

   // frame store
   logic signed [srar_pkg::SAMPLE_BITS-1:0] left_mem  [srar_pkg::RING_FRAMES];
   logic signed [srar_pkg::SAMPLE_BITS-1:0] right_mem [srar_pkg::RING_FRAMES];
   logic signed [srar_pkg::SAMPLE_BITS-1:0] rd0_left_ff;
   logic signed [srar_pkg::SAMPLE_BITS-1:0] rd1_left_ff;
   logic signed [srar_pkg::SAMPLE_BITS-1:0] rd0_right_ff;
   logic signed [srar_pkg::SAMPLE_BITS-1:0] rd1_right_ff;

   // datapath registers
   logic [srar_pkg::FRACTION_BITS-1:0]          frac_ff;
   logic signed [srar_pkg::GAIN_PROD_BITS-1:0]  gain_prod_ff;
   logic [srar_pkg::ADJ_BITS-1:0]               adj_ff;
   logic signed [srar_pkg::INTERP_BITS-1:0]     interp_left_ff;
   logic signed [srar_pkg::INTERP_BITS-1:0]     interp_right_ff;
   logic [srar_pkg::POS_BITS-1:0]               step_ff;
   logic signed [srar_pkg::SAMPLE_BITS-1:0]     res_left_ff;
   logic signed [srar_pkg::SAMPLE_BITS-1:0]     res_right_ff;
   logic                                        res_under_ff;
   logic                                        res_over_ff;

   // result register
   logic                                    out_valid_ff;
   logic signed [srar_pkg::SAMPLE_BITS-1:0] out_left_ff;
   logic signed [srar_pkg::SAMPLE_BITS-1:0] out_right_ff;
   logic                                    out_under_ff;
   logic                                    out_over_ff;
   logic [srar_pkg::FILL_BITS-1:0]          out_fill_ff;
   logic [srar_pkg::COUNT_BITS-1:0]         out_under_total_ff;
   logic [srar_pkg::COUNT_BITS-1:0]         out_over_total_ff;

   // combinational
   logic                                        eval;
   logic                                        is_pop;
   logic [srar_pkg::POS_BITS-1:0]               write_fix;
   logic [srar_pkg::POS_BITS-1:0]               avail_clip;
   logic [srar_pkg::POS_BITS:0]                 push_sum;
   logic                                        over_cond;
   logic [srar_pkg::COUNT_BITS-1:0]             drop_count;
   logic [srar_pkg::POS_BITS-1:0]               push_read;
   logic [srar_pkg::POS_BITS-1:0]               push_avail;
   logic                                        pop_under;
   logic [srar_pkg::FILL_BITS-1:0]              fill_now;
   logic signed [srar_pkg::ERR_BITS-1:0]        fill_err;
   logic signed [srar_pkg::GAIN_PROD_BITS-1:0]  gain_prod;
   logic [srar_pkg::COUNT_BITS-1:0]             idx0;
   logic [srar_pkg::COUNT_BITS-1:0]             idx1;
   logic [srar_pkg::COUNT_BITS-1:0]             ahead;
   logic [srar_pkg::RING_BITS-1:0]              rd_addr0;
   logic [srar_pkg::RING_BITS-1:0]              rd_addr1;
   logic [srar_pkg::RING_BITS-1:0]              wr_addr;
   logic signed [srar_pkg::SUM_BITS-1:0]        gain_sum;
   logic [srar_pkg::ADJ_BITS-1:0]               adj_next;
   logic signed [srar_pkg::DIFF_BITS-1:0]       diff_left;
   logic signed [srar_pkg::DIFF_BITS-1:0]       diff_right;
   logic signed [srar_pkg::FRACTION_BITS:0]     frac_s;
   logic [srar_pkg::STEP_PROD_BITS-1:0]         step_prod;
   logic signed [srar_pkg::INTERP_BITS-1:0]     shift_left;
   logic signed [srar_pkg::INTERP_BITS-1:0]     shift_right;
   logic signed [srar_pkg::POS_BITS-1:0]        avail_after;
   logic [srar_pkg::POS_BITS-1:0]               read_after;
   logic [srar_pkg::FILL_BITS-1:0]              fill_after;
   logic                                        out_load;

   function automatic logic [srar_pkg::FILL_BITS-1:0] fill_of(
      input logic signed [srar_pkg::POS_BITS-1:0] a);
      logic [srar_pkg::POS_BITS-1:0] scaled;
      scaled = a >> srar_pkg::FILL_SHIFT;
      if (a <= 0) begin
         fill_of = '0;
      end else if (a >= $signed(srar_pkg::FULL_FIX)) begin
         fill_of = srar_pkg::FILL_FULL;
      end else begin
         fill_of = scaled[srar_pkg::FILL_BITS-1:0];
      end
   endfunction

   assign q_ready = (state_ff == ST_IDLE);
   assign eval    = q_ready && q_valid;
   assign is_pop  = (q_cmd.kind == srar_pkg::OP_POP);

   assign write_fix = {write_count_ff, {srar_pkg::FRACTION_BITS{1'b0}}};

   // push: clip a stale read position, drop the oldest frame when full
   assign avail_clip = avail_ff[srar_pkg::POS_BITS-1] ? '0 : avail_ff;
   assign push_sum   = {1'b0, avail_clip} + {1'b0, srar_pkg::ONE_FIX};
   assign over_cond  = (push_sum > {1'b0, srar_pkg::FULL_FIX});
   assign drop_count = write_count_ff + 1'b1
                     - srar_pkg::COUNT_BITS'(srar_pkg::RING_FRAMES);

   always_comb begin
      priority if (avail_ff[srar_pkg::POS_BITS-1]) begin
         push_read = write_fix;
      end else if (over_cond) begin
         push_read = {drop_count, {srar_pkg::FRACTION_BITS{1'b0}}};
      end else begin
         push_read = read_pos_ff;
      end
   end

   assign push_avail = over_cond ? srar_pkg::FULL_FIX : push_sum[srar_pkg::POS_BITS-1:0];
   assign wr_addr    = write_count_ff[srar_pkg::RING_BITS-1:0];

   // pop: underrun check, fill error times gain, store addresses
   assign pop_under = (avail_ff < $signed(srar_pkg::ONE_FIX));
   assign fill_now  = fill_of(avail_ff);
   assign fill_err  = $signed({1'b0, fill_now}) - $signed({1'b0, target_fill_ff});
   assign gain_prod = $signed({1'b0, fill_gain_ff}) * fill_err;

   assign idx0     = read_pos_ff[srar_pkg::POS_BITS-1:srar_pkg::FRACTION_BITS];
   assign ahead    = write_count_ff - idx0;
   // hold the second sample when the next frame is not written yet
   assign idx1     = (ahead <= srar_pkg::COUNT_BITS'(1)) ? idx0 : idx0 + 1'b1;
   assign rd_addr0 = idx0[srar_pkg::RING_BITS-1:0];
   assign rd_addr1 = idx1[srar_pkg::RING_BITS-1:0];

   // clamp the adjustment to its allowed band
   assign gain_sum = srar_pkg::UNITY_SUM + srar_pkg::SUM_BITS'(gain_prod_ff);

   always_comb begin
      priority if (gain_sum < srar_pkg::ADJ_LO_SUM) begin
         adj_next = srar_pkg::ADJ_LO;
      end else if (gain_sum > srar_pkg::ADJ_HI_SUM) begin
         adj_next = srar_pkg::ADJ_HI;
      end else begin
         adj_next = gain_sum[srar_pkg::ADJ_SHIFT +: srar_pkg::ADJ_BITS];
      end
   end

   assign diff_left  = srar_pkg::DIFF_BITS'(rd1_left_ff)  - srar_pkg::DIFF_BITS'(rd0_left_ff);
   assign diff_right = srar_pkg::DIFF_BITS'(rd1_right_ff) - srar_pkg::DIFF_BITS'(rd0_right_ff);
   assign frac_s     = $signed({1'b0, frac_ff});

   assign step_prod   = base_ratio_ff * adj_ff;
   assign shift_left  = interp_left_ff  >>> srar_pkg::FRACTION_BITS;
   assign shift_right = interp_right_ff >>> srar_pkg::FRACTION_BITS;

   assign avail_after = avail_ff - step_ff;
   assign read_after  = read_pos_ff + step_ff;
   assign fill_after  = fill_of(avail_after);

   assign out_load = (state_ff == ST_FIN) && (!out_valid_ff || rsp_ch.ready);

   always_comb begin
      unique case (state_ff)
         ST_IDLE: begin
            if (!eval) begin
               state_in = ST_IDLE;
            end else if (is_pop && !pop_under) begin
               state_in = ST_ADJ;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_ADJ:  state_in = ST_STEP;
         ST_STEP: state_in = ST_FIN;
         ST_FIN:  state_in = out_load ? ST_IDLE : ST_FIN;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         base_ratio_ff     <= srar_pkg::BASE_RATIO_RESET;
         fill_gain_ff      <= srar_pkg::FILL_GAIN_RESET;
         target_fill_ff    <= srar_pkg::TARGET_FILL_RESET;
         write_count_ff    <= '0;
         read_pos_ff       <= '0;
         avail_ff          <= '0;
         underrun_count_ff <= '0;
         overrun_count_ff  <= '0;
         under_blk_ff      <= 1'b0;
         over_blk_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            unique case (srar_pkg::csr_index_type'(csr_index))
               srar_pkg::CSR_BASE_RATIO:  base_ratio_ff  <= csr_wdata[srar_pkg::REG_BITS-1:0];
               srar_pkg::CSR_FILL_GAIN:   fill_gain_ff   <= csr_wdata[srar_pkg::REG_BITS-1:0];
               srar_pkg::CSR_TARGET_FILL: target_fill_ff <= csr_wdata[srar_pkg::FILL_BITS-1:0];
               default: ;
            endcase
         end

         if (eval && !is_pop) begin
            write_count_ff <= write_count_ff + 1'b1;
            read_pos_ff    <= push_read;
            avail_ff       <= push_avail;
            if (over_cond && !over_blk_ff && (overrun_count_ff != '1)) begin
               overrun_count_ff <= overrun_count_ff + 1'b1;
            end
            over_blk_ff <= q_cmd.eob ? 1'b0 : (over_blk_ff | over_cond);
         end

         if (eval && is_pop) begin
            if (pop_under && !under_blk_ff && (underrun_count_ff != '1)) begin
               underrun_count_ff <= underrun_count_ff + 1'b1;
            end
            under_blk_ff <= q_cmd.eob ? 1'b0 : (under_blk_ff | pop_under);
         end

         // advance the read position by the pop step; push and underrun carry a zero step
         if (out_load) begin
            read_pos_ff <= read_after;
            avail_ff    <= avail_after;
         end

         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end

      if (eval) begin
         step_ff      <= '0;
         res_left_ff  <= '0;
         res_right_ff <= '0;
         res_under_ff <= is_pop && pop_under;
         res_over_ff  <= !is_pop && over_cond;
         gain_prod_ff <= gain_prod;
         frac_ff      <= read_pos_ff[srar_pkg::FRACTION_BITS-1:0];
      end
      if (state_ff == ST_ADJ) begin
         adj_ff          <= adj_next;
         interp_left_ff  <= diff_left * frac_s;
         interp_right_ff <= diff_right * frac_s;
      end
      if (state_ff == ST_STEP) begin
         step_ff      <= srar_pkg::POS_BITS'(step_prod >> srar_pkg::STEP_SHIFT);
         res_left_ff  <= rd0_left_ff  + shift_left[srar_pkg::SAMPLE_BITS-1:0];
         res_right_ff <= rd0_right_ff + shift_right[srar_pkg::SAMPLE_BITS-1:0];
      end
      if (out_load) begin
         out_left_ff        <= res_left_ff;
         out_right_ff       <= res_right_ff;
         out_under_ff       <= res_under_ff;
         out_over_ff        <= res_over_ff;
         out_fill_ff        <= fill_after;
         out_under_total_ff <= underrun_count_ff;
         out_over_total_ff  <= overrun_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (eval && !is_pop) begin
         left_mem[wr_addr]  <= q_cmd.left;
         right_mem[wr_addr] <= q_cmd.right;
      end
      if (eval && is_pop) begin
         rd0_left_ff  <= left_mem[rd_addr0];
         rd1_left_ff  <= left_mem[rd_addr1];
         rd0_right_ff <= right_mem[rd_addr0];
         rd1_right_ff <= right_mem[rd_addr1];
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.left_out       = out_left_ff;
   assign rsp_ch.right_out      = out_right_ff;
   assign rsp_ch.underrun_now   = out_under_ff;
   assign rsp_ch.overrun_now    = out_over_ff;
   assign rsp_ch.fill_level     = out_fill_ff;
   assign rsp_ch.underrun_total = out_under_total_ff;
   assign rsp_ch.overrun_total  = out_over_total_ff;

   `SRAR_ASSERT(a_avail_tracks_ptrs, avail_ff == (write_fix - read_pos_ff), "fill shadow lost track of pointers")
   `SRAR_ASSERT(a_avail_bounded, $signed(avail_ff) <= $signed(srar_pkg::FULL_FIX), "ring holds more than capacity")
   `SRAR_ASSERT(a_underrun_zero, out_valid_ff && out_under_ff |-> out_left_ff == '0 && out_right_ff == '0, "underrun beat carries samples")
   `SRAR_ASSERT_NEVER(a_flags_excl, out_valid_ff && out_under_ff && out_over_ff, "underrun and overrun on one beat")

endmodule

// ----- hdl/stereo_ring_async_resampler_core.sv -----
// Stereo ring resampler with fractional read position and linear interpolation.
// Depends on srar_pkg, srar_chan_if, srar_front and srar_back.
//
// Usage:
//   req_ch carries push (operation 0) and pop (operation 1) beats; every request
//   beat yields exactly one rsp_ch beat, in order. csr_we/csr_index/csr_wdata
//   write base_ratio, fill_gain and target_fill; write them while the block is idle.
//   A request lands in a four-entry command queue, so req_ch keeps accepting while
//   the execution engine works or the response waits.
//   The engine runs one command at a time. A pop passes through the chain gain
//   multiply, clamp, ratio multiply and pointer update, one register stage each;
//   a push or an underrun pop goes from accept straight to ST_FIN.
//   Synchronous reset clears pointers, counts and block flags and restores the
//   register defaults; the frame store is not cleared and needs no sweep.
//   When rsp_ch stalls, the response register holds its beat, the engine waits
//   with the next result, and the queue fills until req_ch drops ready.
module stereo_ring_async_resampler_core (
   input  logic                                  clock,
   input  logic                                  reset,
   srar_req_if.sink                              req_ch,
   srar_rsp_if.source                            rsp_ch,
   input  logic                                  csr_we,
   input  logic [srar_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [srar_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   logic               q_valid;
   logic               q_ready;
   srar_pkg::cmd_type  q_cmd;

   srar_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .q_cmd   (q_cmd)
   );

   srar_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_cmd     (q_cmd),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for stereo_ring_async_resampler_core: push/pop beats, CSR phases.
// Depends on srar_pkg and the srar_req_if / srar_rsp_if channel interfaces.
module tb_top;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam logic signed [srar_pkg::SAMPLE_BITS-1:0] SAMPLE_MAX =
      {1'b0, {(srar_pkg::SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [srar_pkg::SAMPLE_BITS-1:0] SAMPLE_MIN =
      {1'b1, {(srar_pkg::SAMPLE_BITS-1){1'b0}}};
   localparam longint ONE_FRAME = longint'(1) << srar_pkg::FRACTION_BITS;
   localparam longint FULL_RING = longint'(srar_pkg::RING_FRAMES) << srar_pkg::FRACTION_BITS;
   // rate trim limits, 0.995 and 1.005 in Q.40
   localparam longint TRIM_FLOOR = longint'(16693330) << 16;
   localparam longint TRIM_CEIL  = longint'(16861102) << 16;

   typedef struct {
      logic signed [srar_pkg::SAMPLE_BITS-1:0] left;
      logic signed [srar_pkg::SAMPLE_BITS-1:0] right;
      logic                                    underrun;
      logic                                    overrun;
      logic [srar_pkg::FILL_BITS-1:0]          fill;
      logic [srar_pkg::COUNT_BITS-1:0]         underrun_total;
      logic [srar_pkg::COUNT_BITS-1:0]         overrun_total;
   } frame_out_type;

   typedef enum {RX_OPEN, RX_RANDOM, RX_DUTY, RX_LONG} stall_mode_type;

   class ring_resampler_sb_type;
      logic signed [srar_pkg::SAMPLE_BITS-1:0] left_mem [srar_pkg::RING_FRAMES];
      logic signed [srar_pkg::SAMPLE_BITS-1:0] right_mem [srar_pkg::RING_FRAMES];
      logic [srar_pkg::COUNT_BITS-1:0]         write_count;
      logic [srar_pkg::POS_BITS-1:0]           read_pos;
      logic [srar_pkg::COUNT_BITS-1:0]         underrun_count;
      logic [srar_pkg::COUNT_BITS-1:0]         overrun_count;
      bit                                      underrun_flag;
      bit                                      overrun_flag;
      logic [srar_pkg::REG_BITS-1:0]           base_ratio;
      logic [srar_pkg::REG_BITS-1:0]           fill_gain;
      logic [srar_pkg::FILL_BITS-1:0]          target_fill;
      frame_out_type                           due_frames[$];
      int unsigned errors, pushes, pops, overruns, underruns, held, ahead;

      function new();
         foreach (left_mem[i]) begin
            left_mem[i] = '0;
            right_mem[i] = '0;
         end
         write_count = '0;
         read_pos = '0;
         underrun_count = '0;
         overrun_count = '0;
         underrun_flag = 0;
         overrun_flag = 0;
         base_ratio = srar_pkg::BASE_RATIO_RESET;
         fill_gain = srar_pkg::FILL_GAIN_RESET;
         target_fill = srar_pkg::TARGET_FILL_RESET;
      endfunction

      function void set_register(srar_pkg::csr_index_type idx,
                                 logic [srar_pkg::CSR_DATA_BITS-1:0] value);
         case (idx)
            srar_pkg::CSR_BASE_RATIO:  base_ratio = value;
            srar_pkg::CSR_FILL_GAIN:   fill_gain = value;
            srar_pkg::CSR_TARGET_FILL: target_fill = value[srar_pkg::FILL_BITS-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return due_frames.size();
      endfunction

      // written frames minus read position, signed, in position units
      function longint frames_ahead();
         logic signed [srar_pkg::POS_BITS-1:0] gap;
         gap = {write_count, {srar_pkg::FRACTION_BITS{1'b0}}} - read_pos;
         return longint'(gap);
      endfunction

      function logic [srar_pkg::FILL_BITS-1:0] fill_fraction(longint avail);
         if (avail <= 0) return '0;
         if (avail >= FULL_RING) return srar_pkg::FILL_FULL;
         return srar_pkg::FILL_BITS'((avail * 65536) / FULL_RING);
      endfunction

      function longint unsigned read_step(logic [srar_pkg::FILL_BITS-1:0] fill);
         longint err;
         longint trim;
         err = longint'(fill) - longint'(target_fill);
         trim = (longint'(1) << 40) + longint'(fill_gain) * err;
         if (trim < TRIM_FLOOR) trim = TRIM_FLOOR;
         if (trim > TRIM_CEIL) trim = TRIM_CEIL;
         trim = trim >>> 16;
         return (longint'(base_ratio) * trim) >> (48 - srar_pkg::FRACTION_BITS);
      endfunction

      function logic signed [srar_pkg::SAMPLE_BITS-1:0] blend(
         logic signed [srar_pkg::SAMPLE_BITS-1:0] s0,
         logic signed [srar_pkg::SAMPLE_BITS-1:0] s1,
         logic [srar_pkg::FRACTION_BITS-1:0] frac);
         longint prod;
         longint mixed;
         prod = (longint'(s1) - longint'(s0)) * longint'(frac);
         // arithmetic shift floors toward minus infinity
         mixed = longint'(s0) + (prod >>> srar_pkg::FRACTION_BITS);
         return srar_pkg::SAMPLE_BITS'(mixed);
      endfunction

      function void note_request(srar_pkg::cmd_type beat);
         frame_out_type res;
         longint avail;
         logic [srar_pkg::COUNT_BITS-1:0] i0, i1, span;
         res = '{default: '0};
         avail = frames_ahead();
         if (beat.kind == srar_pkg::OP_PUSH) begin
            pushes++;
            if (avail < 0) begin
               ahead++;
               read_pos = {write_count, {srar_pkg::FRACTION_BITS{1'b0}}};
               avail = 0;
            end
            // ring full: drop the oldest frame
            if (avail + ONE_FRAME > FULL_RING) begin
               read_pos = read_pos + srar_pkg::POS_BITS'(avail + ONE_FRAME - FULL_RING);
               res.overrun = 1'b1;
               overruns++;
               if (!overrun_flag) begin
                  if (overrun_count != '1) overrun_count++;
                  overrun_flag = 1;
               end
            end
            left_mem[write_count % srar_pkg::RING_FRAMES] = beat.left;
            right_mem[write_count % srar_pkg::RING_FRAMES] = beat.right;
            write_count++;
            if (beat.eob) overrun_flag = 0;
         end else begin
            pops++;
            if (avail < ONE_FRAME) begin
               res.underrun = 1'b1;
               underruns++;
               if (!underrun_flag) begin
                  if (underrun_count != '1) underrun_count++;
                  underrun_flag = 1;
               end
            end else begin
               i0 = read_pos[srar_pkg::POS_BITS-1:srar_pkg::FRACTION_BITS];
               i1 = i0 + 1;
               span = write_count - i0;
               // hold the second sample when the next frame is not written yet
               if (span <= 1) begin
                  i1 = i0;
                  held++;
               end
               res.left = blend(left_mem[i0 % srar_pkg::RING_FRAMES],
                                left_mem[i1 % srar_pkg::RING_FRAMES],
                                read_pos[srar_pkg::FRACTION_BITS-1:0]);
               res.right = blend(right_mem[i0 % srar_pkg::RING_FRAMES],
                                 right_mem[i1 % srar_pkg::RING_FRAMES],
                                 read_pos[srar_pkg::FRACTION_BITS-1:0]);
               read_pos = read_pos + srar_pkg::POS_BITS'(read_step(fill_fraction(avail)));
            end
            if (beat.eob) underrun_flag = 0;
         end
         res.fill = fill_fraction(frames_ahead());
         res.underrun_total = underrun_count;
         res.overrun_total = overrun_count;
         due_frames.push_back(res);
      endfunction

      function void compare(string field, logic signed [63:0] want, logic signed [63:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            errors++;
         end
      endfunction

      function void check_response(frame_out_type got);
         frame_out_type want;
         if (due_frames.size() == 0) begin
            $error("response beat with no request outstanding");
            errors++;
            return;
         end
         want = due_frames.pop_front();
         compare("left_out", 64'(want.left), 64'(got.left));
         compare("right_out", 64'(want.right), 64'(got.right));
         compare("underrun_now", 64'(want.underrun), 64'(got.underrun));
         compare("overrun_now", 64'(want.overrun), 64'(got.overrun));
         compare("fill_level", 64'(want.fill), 64'(got.fill));
         compare("underrun_total", 64'(want.underrun_total), 64'(got.underrun_total));
         compare("overrun_total", 64'(want.overrun_total), 64'(got.overrun_total));
      endfunction
   endclass

   logic                                  clock;
   logic                                  reset;
   logic                                  csr_we;
   logic [srar_pkg::CSR_INDEX_BITS-1:0]   csr_index;
   logic [srar_pkg::CSR_DATA_BITS-1:0]    csr_wdata;

   srar_req_if req_ch();
   srar_rsp_if rsp_ch();

   stereo_ring_async_resampler_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ring_resampler_sb_type sb = new();

   int unsigned       cycles = 0;
   int unsigned       burst_left = 0;
   int unsigned       rx_cycle = 0;
   int unsigned       rx_hold = 0;
   stall_mode_type    rx_mode = RX_OPEN;
   srar_pkg::cmd_type seen_req;
   frame_out_type     seen_rsp;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d beats outstanding", cycles, sb.pending());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // monitor: note accepted requests before checking responses
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            seen_req.kind = srar_pkg::op_type'(req_ch.operation);
            seen_req.eob = req_ch.end_of_block;
            seen_req.left = req_ch.left_in;
            seen_req.right = req_ch.right_in;
            sb.note_request(seen_req);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen_rsp.left = rsp_ch.left_out;
            seen_rsp.right = rsp_ch.right_out;
            seen_rsp.underrun = rsp_ch.underrun_now;
            seen_rsp.overrun = rsp_ch.overrun_now;
            seen_rsp.fill = rsp_ch.fill_level;
            seen_rsp.underrun_total = rsp_ch.underrun_total;
            seen_rsp.overrun_total = rsp_ch.overrun_total;
            sb.check_response(seen_rsp);
         end
      end
   end

   // receiver backpressure, switching at random among open, random, duty and long-hold patterns
   always @(negedge clock) begin
      rx_cycle++;
      if (rx_cycle % 250 == 0) rx_mode = stall_mode_type'($urandom_range(3));
      case (rx_mode)
         RX_OPEN:   rsp_ch.ready = 1'b1;
         RX_RANDOM: rsp_ch.ready = ($urandom_range(3) != 0);
         RX_DUTY:   rsp_ch.ready = ((rx_cycle % 7) < 4);
         default: begin
            if (rx_hold != 0) begin
               rx_hold--;
            end else begin
               rsp_ch.ready = !rsp_ch.ready;
               rx_hold = $urandom_range(10);
            end
         end
      endcase
   end

   function automatic logic signed [srar_pkg::SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(9))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return '0;
         3: return '1;
         default: return srar_pkg::SAMPLE_BITS'($urandom);
      endcase
   endfunction

   task automatic go_idle();
      req_ch.valid = 1'b0;
      req_ch.operation = 1'($urandom_range(1));
      req_ch.left_in = srar_pkg::SAMPLE_BITS'($urandom);
      req_ch.right_in = srar_pkg::SAMPLE_BITS'($urandom);
      req_ch.end_of_block = 1'($urandom_range(1));
   endtask

   // starts and ends on a falling edge
   task automatic send_beat(srar_pkg::op_type kind, logic signed [srar_pkg::SAMPLE_BITS-1:0] l,
                            logic signed [srar_pkg::SAMPLE_BITS-1:0] r, logic eob);
      req_ch.valid = 1'b1;
      req_ch.operation = kind;
      req_ch.left_in = l;
      req_ch.right_in = r;
      req_ch.end_of_block = eob;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic pace();
      int unsigned gap;
      if (burst_left != 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
         go_idle();
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain_all();
      go_idle();
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic write_reg(srar_pkg::csr_index_type idx,
                            logic [srar_pkg::CSR_DATA_BITS-1:0] value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      sb.set_register(idx, value);
   endtask

   task automatic directed_checks();
      // underruns on an empty ring, counted once per block
      send_beat(srar_pkg::OP_POP, '0, '0, 1'b0);
      send_beat(srar_pkg::OP_POP, '0, '0, 1'b1);
      send_beat(srar_pkg::OP_POP, '0, '0, 1'b1);
      // single frame: pop holds the second sample, then runs dry
      send_beat(srar_pkg::OP_PUSH, SAMPLE_MAX, SAMPLE_MIN, 1'b1);
      send_beat(srar_pkg::OP_POP, '0, '0, 1'b0);
      send_beat(srar_pkg::OP_POP, '0, '0, 1'b1);
      send_beat(srar_pkg::OP_PUSH, SAMPLE_MIN, SAMPLE_MAX, 1'b0);
      send_beat(srar_pkg::OP_PUSH, '0, '1, 1'b0);
      send_beat(srar_pkg::OP_PUSH, '1, '0, 1'b0);
      send_beat(srar_pkg::OP_PUSH, SAMPLE_MAX, SAMPLE_MAX, 1'b1);
      repeat (6) send_beat(srar_pkg::OP_POP, '0, '0, 1'b0);
      send_beat(srar_pkg::OP_POP, '0, '0, 1'b1);
      send_beat(srar_pkg::OP_PUSH, SAMPLE_MIN, SAMPLE_MIN, 1'b0);
      send_beat(srar_pkg::OP_PUSH, 24'sh000001, -24'sh000002, 1'b1);
      send_beat(srar_pkg::OP_POP, '0, '0, 1'b0);
      send_beat(srar_pkg::OP_POP, '0, '0, 1'b0);
      send_beat(srar_pkg::OP_POP, '0, '0, 1'b1);
   endtask

   task automatic run_phase(logic [srar_pkg::REG_BITS-1:0] ratio,
                            logic [srar_pkg::REG_BITS-1:0] gain,
                            logic [srar_pkg::REG_BITS-1:0] target, int items, int push_pct);
      int sent;
      int len;
      srar_pkg::op_type kind;
      srar_pkg::op_type beat_kind;
      logic eob;
      bit paused;
      drain_all();
      write_reg(srar_pkg::CSR_BASE_RATIO, ratio);
      write_reg(srar_pkg::CSR_FILL_GAIN, gain);
      write_reg(srar_pkg::CSR_TARGET_FILL, target);
      sent = 0;
      paused = 0;
      while (sent < items) begin
         kind = ($urandom_range(99) < push_pct) ? srar_pkg::OP_PUSH : srar_pkg::OP_POP;
         len = ($urandom_range(7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
         for (int k = 0; k < len; k++) begin
            eob = (k == len - 1);
            beat_kind = kind;
            // occasional broken block: stray marker or foreign beat
            if ($urandom_range(19) == 0) eob = 1'($urandom_range(1));
            if ($urandom_range(19) == 0) beat_kind = srar_pkg::op_type'(!kind);
            send_beat(beat_kind, pick_sample(), pick_sample(), eob);
            pace();
         end
         sent += len;
         // hold the sender until every response is back
         if (!paused && sent >= items / 2) begin
            drain_all();
            paused = 1;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = srar_pkg::CSR_BASE_RATIO;
      csr_wdata = '0;
      rsp_ch.ready = 1'b0;
      go_idle();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed_checks();
      // unity rate, no trim: integer read steps
      run_phase(32'h0100_0000, 32'd0, 32'd0, 24, 50);
      // 44.1k into 48k with moderate trim
      run_phase(32'd15414067, 32'h0040_0000, 32'd16384, 40, 55);
      // near-zero step, full gain: fill the ring into overrun
      run_phase(32'd1, 32'hFFFF_FFFF, 32'd0, 1080, 100);
      // largest step: drain and overshoot the write side
      run_phase(32'hFFFF_FFFF, 32'd0, 32'd65536, 30, 50);
      // zero step, target above full scale
      run_phase(32'd0, 32'h0010_0000, 32'h1_FFFF, 24, 60);
      repeat (2)
         run_phase($urandom_range(32'h0080_0000, 32'h0200_0000), $urandom,
                   $urandom_range(65536), 12, 50);
      drain_all();
      repeat (12) @(negedge clock);

      $display("Run covered %0d pushes and %0d pops: %0d overrun beats, %0d underrun beats.",
               sb.pushes, sb.pops, sb.overruns, sb.underruns);
      $display("%0d pops held the second sample, %0d pushes found the read side ahead.",
               sb.held, sb.ahead);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
